/* sv/xkr_pkg.sv */
// ----------------------------------------------------------------------------
// xkr_pkg
// Shared types, codes and signature tables for the XOR key recovery decoder.
// ----------------------------------------------------------------------------
package xkr_pkg;

  localparam int unsigned NumSigs   = 7;
  localparam int unsigned HdrBytes  = 4;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Report status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // File type codes.
  localparam logic [2:0] TYPE_JPG     = 3'd0;
  localparam logic [2:0] TYPE_PNG     = 3'd1;
  localparam logic [2:0] TYPE_BMP     = 3'd2;
  localparam logic [2:0] TYPE_GIF     = 3'd3;
  localparam logic [2:0] TYPE_PDF     = 3'd4;
  localparam logic [2:0] TYPE_ZIP     = 3'd5;
  localparam logic [2:0] TYPE_AVI     = 3'd6;
  localparam logic [2:0] TYPE_UNKNOWN = 3'd7;

  typedef logic [HdrBytes-1:0][7:0] hdr_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic [2:0] file_type;
    logic       status;
    logic       last;
  } result_t;

  // Up to three results produced by one input transaction.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r2;
    result_t    r1;
    result_t    r0;
  } bundle_t;

  // First and second bytes of the known two-byte file signatures.
  function automatic logic [7:0] sig_first(input logic [2:0] i);
    logic [7:0] v;
    v = 8'h00;
    case (i)
      3'd0:    v = 8'hFF;
      3'd1:    v = 8'h89;
      3'd2:    v = 8'h42;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h50;
      3'd5:    v = 8'h52;
      3'd6:    v = 8'h41;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] sig_second(input logic [2:0] i);
    logic [7:0] v;
    v = 8'h00;
    case (i)
      3'd0:    v = 8'hD8;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4D;
      3'd3:    v = 8'h49;
      3'd4:    v = 8'h4B;
      3'd5:    v = 8'h61;
      3'd6:    v = 8'h56;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Recovers the key from the first two raw bytes; zero means no match.
  // The first matching signature wins.
  function automatic logic [7:0] find_key(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] k;
    logic       hit;
    k   = 8'h00;
    hit = 1'b0;
    for (int i = 0; i < NumSigs; i++) begin
      if (!hit && ((a ^ b) == (sig_first(3'(i)) ^ sig_second(3'(i))))) begin
        hit = 1'b1;
        k   = a ^ sig_first(3'(i));
      end
    end
    return k;
  endfunction

  // Classifies a file from its first decoded bytes; missing bytes never match.
  function automatic logic [2:0] classify(input hdr_t h, input logic [2:0] pos);
    logic [HdrBytes-1:0] have;
    logic [2:0]          t;
    for (int i = 0; i < HdrBytes; i++) begin
      have[i] = (3'(i) < pos);
    end
    if (have[2] && h[0] == 8'hFF && h[1] == 8'hD8 && h[2] == 8'hFF)
      t = TYPE_JPG;
    else if (have[3] && h[0] == 8'h89 && h[1] == 8'h50 && h[2] == 8'h4E && h[3] == 8'h47)
      t = TYPE_PNG;
    else if (have[1] && h[0] == 8'h42 && h[1] == 8'h4D)
      t = TYPE_BMP;
    else if (have[2] && h[0] == 8'h47 && h[1] == 8'h49 && h[2] == 8'h46)
      t = TYPE_GIF;
    else if (have[3] && h[0] == 8'h25 && h[1] == 8'h50 && h[2] == 8'h44 && h[3] == 8'h46)
      t = TYPE_PDF;
    else if (have[1] && h[0] == 8'h50 && h[1] == 8'h4B)
      t = TYPE_ZIP;
    else if (have[3] && h[0] == 8'h52 && h[1] == 8'h49 && h[2] == 8'h46 && h[3] == 8'h46)
      t = TYPE_AVI;
    else
      t = TYPE_UNKNOWN;
    return t;
  endfunction

endpackage

/* sv/xkr_decode.sv */
// ----------------------------------------------------------------------------
// xkr_decode
// Per-file state, key recovery, byte decoding and end-of-file reporting.
// ----------------------------------------------------------------------------
module xkr_decode import xkr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] raw_byte,
  input  logic       eof,
  output bundle_t    bundle
);

  logic [7:0] xor_key, xor_key_next;
  logic       key_known, key_known_next;
  logic [7:0] held, held_next;
  logic [2:0] pos, pos_next;
  hdr_t       hdr, hdr_next;
  logic       dropped, dropped_next;

  logic [2:0] pos_upd;
  hdr_t       hdr_upd;
  logic       dropped_upd;
  logic [7:0] held_upd;
  logic [7:0] key_found;
  logic [7:0] dec;
  logic [1:0] nd;
  logic [7:0] d0, d1;
  result_t    rep;

  always_comb begin
    xor_key_next   = xor_key;
    key_known_next = key_known;
    held_upd       = held;
    pos_upd        = pos;
    hdr_upd        = hdr;
    dropped_upd    = dropped;
    nd             = 2'd0;
    d0             = 8'h00;
    d1             = 8'h00;
    key_found      = find_key(held, raw_byte);
    dec            = raw_byte ^ xor_key;

    if (dropped) begin
      // Remaining bytes of a dropped file are discarded.
    end else if (!key_known) begin
      if (pos == 3'd0) begin
        held_upd = raw_byte;
        pos_upd  = 3'd1;
      end else if (key_found != 8'h00) begin
        xor_key_next   = key_found;
        key_known_next = 1'b1;
        hdr_upd[0]     = held ^ key_found;
        hdr_upd[1]     = raw_byte ^ key_found;
        pos_upd        = 3'd2;
        nd             = 2'd2;
        d0             = held ^ key_found;
        d1             = raw_byte ^ key_found;
      end else begin
        dropped_upd = 1'b1;
      end
    end else begin
      if (pos < 3'(HdrBytes)) begin
        hdr_upd[pos[1:0]] = dec;
        pos_upd           = pos + 3'd1;
      end
      nd = 2'd1;
      d0 = dec;
    end

    rep.kind     = KIND_REPORT;
    rep.out_byte = 8'h00;
    rep.last     = 1'b1;
    if (dropped_upd || !key_known_next) begin
      rep.file_type = TYPE_UNKNOWN;
      rep.status    = STATUS_DROPPED;
    end else begin
      rep.file_type = classify(hdr_upd, pos_upd);
      rep.status    = STATUS_OK;
    end

    bundle.cnt = nd + {1'b0, eof};
    bundle.r0  = '{kind: KIND_DATA, out_byte: d0, file_type: TYPE_JPG,
                   status: STATUS_OK, last: 1'b0};
    bundle.r1  = '{kind: KIND_DATA, out_byte: d1, file_type: TYPE_JPG,
                   status: STATUS_OK, last: 1'b0};
    bundle.r2  = rep;
    if (nd == 2'd0) begin
      bundle.r0 = rep;
    end
    if (nd != 2'd2) begin
      bundle.r1 = rep;
    end
    bundle.r0.last = (bundle.cnt == 2'd1);
    bundle.r1.last = (bundle.cnt == 2'd2);

    // The report closes the file: per-file state starts over, the key stays.
    if (eof) begin
      pos_next     = 3'd0;
      dropped_next = 1'b0;
      held_next    = 8'h00;
      hdr_next     = '0;
    end else begin
      pos_next     = pos_upd;
      dropped_next = dropped_upd;
      held_next    = held_upd;
      hdr_next     = hdr_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key   <= 8'h00;
      key_known <= 1'b0;
      held      <= 8'h00;
      pos       <= 3'd0;
      hdr       <= '0;
      dropped   <= 1'b0;
    end else if (fire) begin
      xor_key   <= xor_key_next;
      key_known <= key_known_next;
      held      <= held_next;
      pos       <= pos_next;
      hdr       <= hdr_next;
      dropped   <= dropped_next;
    end
  end

endmodule

/* sv/xkr_emit.sv */
// ----------------------------------------------------------------------------
// xkr_emit
// Result register: holds the results of one transaction and sends them out
// one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module xkr_emit import xkr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  bundle_t    bundle,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] out_byte,
  output logic [2:0] file_type,
  output logic       status,
  output logic       last
);

  logic [1:0] cnt;
  logic [1:0] idx;
  result_t    slot0, slot1, slot2;
  result_t    cur;
  logic       on_last;

  always_comb begin
    case (idx)
      2'd0:    cur = slot0;
      2'd1:    cur = slot1;
      default: cur = slot2;
    endcase
  end

  assign on_last   = (idx + 2'd1 == cnt);
  assign out_valid = (cnt != 2'd0);
  assign ready     = !out_valid || (on_last && !out_stall);

  assign kind      = cur.kind;
  assign out_byte  = cur.out_byte;
  assign file_type = cur.file_type;
  assign status    = cur.status;
  assign last      = cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= bundle.cnt;
      idx <= 2'd0;
    end else if (out_valid && !out_stall) begin
      if (on_last) begin
        cnt <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= bundle.r0;
      slot1 <= bundle.r1;
      slot2 <= bundle.r2;
    end
  end

endmodule

/* sv/xor_key_recovery_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// xor_key_recovery_stream_decoder_top
// Recovers a one-byte XOR key from file signatures and decodes a byte stream.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   in_byte, end_of_file
//   output    out_valid / out_stall kind, out_byte, file_type, status, last
//
// A transaction is accepted when valid is high and stall is low.
// An input byte waits in the input register and then moves all its results
// into the result register in one step; the block takes one byte per cycle
// as long as each byte gives at most one result and out_stall is low.
// A byte that gives two or three results (key learned, end-of-file report)
// sends them one result per cycle while out_stall is low; the next byte waits
// in the input register and further input stalls. Reset is synchronous and
// active high; it clears the key and all file state. in_stall follows
// out_stall combinationally while a byte waits and the last result is shown.
module xor_key_recovery_stream_decoder_top import xkr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] out_byte,
  output logic [2:0] file_type,
  output logic       status,
  output logic       last
);

  // Input register.
  logic       in_full;
  logic [7:0] raw_byte;
  logic       raw_eof;

  logic       emit_ready;
  logic       advance;
  logic       accept;
  bundle_t    bundle;

  // The buffered byte moves on whenever the result register can take its
  // results this cycle; the input register is then free for the next byte.
  assign advance  = in_full && emit_ready;
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_byte <= in_byte;
      raw_eof  <= end_of_file;
    end
  end

  // Key recovery and decoding; state updates as the byte leaves the register.
  xkr_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .raw_byte (raw_byte),
    .eof      (raw_eof),
    .bundle   (bundle)
  );

  // Result register and output sequencing.
  xkr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .bundle    (bundle),
    .ready     (emit_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte),
    .file_type (file_type),
    .status    (status),
    .last      (last)
  );

endmodule

/* sv/xkr_checker.sv */
// ----------------------------------------------------------------------------
// xkr_checker
// Port-level checks on the result channel of the decoder.
// ----------------------------------------------------------------------------
module xkr_checker import xkr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [7:0] out_byte,
  input logic [2:0] file_type,
  input logic       status,
  input logic       last
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(file_type) && $stable(status) && $stable(last))
    else $error("stalled result changed");

  // Nothing comes out right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A report always closes the results of its transaction and carries no byte.
  a_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_REPORT |-> last && out_byte == 8'h00)
    else $error("malformed report");

  // A dropped file is always of unknown type; data results carry no report.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_DROPPED |-> kind == KIND_REPORT
      && file_type == TYPE_UNKNOWN)
    else $error("bad drop status");

endmodule

bind xor_key_recovery_stream_decoder_top xkr_checker u_xkr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .out_byte  (out_byte),
  .file_type (file_type),
  .status    (status),
  .last      (last)
);
